// ----- hw/rtl/cwa_pkg.sv -----
// ----------------------------------------------------------------------------
// cwa_pkg
// shared types and character codes for the csv word to ascii pair converter
// ----------------------------------------------------------------------------
`default_nettype none

package cwa_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned AccumW = 16;

    localparam logic [CharW-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CharW-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CharW-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CharW-1:0] CHAR_VT      = 8'h0B;
    localparam logic [CharW-1:0] CHAR_FF      = 8'h0C;
    localparam logic [CharW-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CharW-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CharW-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CharW-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [CharW-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CharW-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CharW-1:0] CHAR_NINE    = 8'h39;

    localparam logic [AccumW-1:0] WORD_DROP      = 16'd2560;
    localparam logic [AccumW-1:0] WORD_HIGH_ONLY = 16'd3338;
    localparam logic [AccumW-1:0] ACCUM_MAX      = 16'hFFFF;

    // number scan phases
    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_NUM  = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;

    // bytes produced by one input character
    typedef struct packed {
        logic [1:0]       n;
        logic [CharW-1:0] hi;
        logic [CharW-1:0] lo;
    } t_emit;

endpackage : cwa_pkg

`default_nettype wire

// ----- hw/rtl/csv_word_to_ascii_pairs.sv -----
// ----------------------------------------------------------------------------
// csv_word_to_ascii_pairs
// parses comma-separated decimal words from a character stream, emits bytes
// ----------------------------------------------------------------------------
// output: the first result byte is registered and appears in the cycle after its comma request is taken
// throughput: one character per cycle while the sink takes each byte; a character that gives two bytes holds
//   the input until its second byte leaves the buffer
// reset: synchronous active-low i_rst_n clears the line state and the buffer
`default_nettype none

module csv_word_to_ascii_pairs
    import cwa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [CharW-1:0] s_axis_tdata,   // [7:0] in_char
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [CharW-1:0]      m_axis_tdata,   // [7:0] out_byte
    output logic                  m_axis_tlast    // last_of_run
);

    logic  take;
    t_emit emit;

    assign take = s_axis_tvalid && s_axis_tready;

    cwa_field_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_char  (s_axis_tdata),
        .o_emit  (emit)
    );

    cwa_out_buf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take),
        .i_emit      (emit),
        .i_out_ready (m_axis_tready),
        .o_room      (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule : csv_word_to_ascii_pairs

`default_nettype wire

// ----- hw/rtl/cwa_field_scan.sv -----
// ----------------------------------------------------------------------------
// cwa_field_scan
// per-character field parser: holds line and number state, decides the bytes
// ----------------------------------------------------------------------------
`default_nettype none

module cwa_field_scan
    import cwa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [CharW-1:0] i_char,
    output t_emit                 o_emit
);

    logic              r_past_first, n_past_first;
    logic              r_stopped, n_stopped;
    logic              r_nonempty, n_nonempty;
    logic [1:0]        r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [AccumW-1:0] r_accum, n_accum;

    logic              is_digit;
    logic              is_blank;
    logic              is_sign;
    logic [AccumW+3:0] mac;
    logic [AccumW-1:0] acc_sat;
    logic              emit_ok;

    assign is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign is_blank = (i_char == CHAR_SPACE) || (i_char == CHAR_TAB) ||
                      (i_char == CHAR_VT) || (i_char == CHAR_FF) ||
                      (i_char == CHAR_CR);
    assign is_sign  = (i_char == CHAR_PLUS) || (i_char == CHAR_MINUS);

    // acc*10 + digit as two shifts and adds, then saturate
    assign mac = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) +
                 {{(AccumW+4-4){1'b0}}, i_char[3:0]};
    assign acc_sat = (mac > {4'd0, ACCUM_MAX}) ? ACCUM_MAX : mac[AccumW-1:0];

    assign emit_ok = !r_neg && (r_accum != '0) && (r_accum != WORD_DROP);

    always_comb begin
        n_past_first = r_past_first;
        n_stopped    = r_stopped;
        n_nonempty   = r_nonempty;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_accum      = r_accum;
        o_emit.n     = 2'd0;
        o_emit.hi    = r_accum[AccumW-1:CharW];
        o_emit.lo    = r_accum[CharW-1:0];

        if (i_char == CHAR_NEWLINE) begin
            n_past_first = 1'b0;
            n_stopped    = 1'b0;
            n_nonempty   = 1'b0;
            n_phase      = PH_LEAD;
            n_neg        = 1'b0;
            n_accum      = '0;
        end else if (r_stopped) begin
            // rest of line ignored
        end else if (i_char == CHAR_NUL || i_char == CHAR_COMMA) begin
            n_nonempty = 1'b0;
            n_phase    = PH_LEAD;
            n_neg      = 1'b0;
            n_accum    = '0;
            if (i_char == CHAR_NUL) begin
                n_stopped = 1'b1;
            end else if (!r_past_first) begin
                n_past_first = 1'b1;
            end else if (!r_nonempty) begin
                n_stopped = 1'b1;
            end else if (emit_ok) begin
                o_emit.n = (r_accum == WORD_HIGH_ONLY) ? 2'd1 : 2'd2;
            end
        end else begin
            n_nonempty = 1'b1;
            case (r_phase)
                PH_LEAD: begin
                    if (is_sign) begin
                        n_neg   = (i_char == CHAR_MINUS);
                        n_phase = PH_NUM;
                    end else if (is_digit) begin
                        n_phase = PH_NUM;
                        n_accum = acc_sat;
                    end else if (!is_blank) begin
                        n_phase = PH_END;
                    end
                end
                PH_NUM: begin
                    if (is_digit) begin
                        n_accum = acc_sat;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_past_first <= 1'b0;
            r_stopped    <= 1'b0;
            r_nonempty   <= 1'b0;
            r_phase      <= PH_LEAD;
            r_neg        <= 1'b0;
            r_accum      <= '0;
        end else if (i_take) begin
            r_past_first <= n_past_first;
            r_stopped    <= n_stopped;
            r_nonempty   <= n_nonempty;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_accum      <= n_accum;
        end
    end

`ifndef SYNTHESIS
    a_emit_only_on_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_emit.n != 2'd0) |-> (i_char == CHAR_COMMA))
        else $error("bytes emitted on a non-comma character");

    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_char == CHAR_NEWLINE) |=>
            (!r_stopped && !r_past_first && r_accum == '0))
        else $error("line end did not clear the line state");
`endif

endmodule : cwa_field_scan

`default_nettype wire

// ----- hw/rtl/cwa_out_buf.sv -----
// ----------------------------------------------------------------------------
// cwa_out_buf
// two-entry result buffer: holds the bytes of one character and streams them
// ----------------------------------------------------------------------------
`default_nettype none

module cwa_out_buf
    import cwa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire t_emit            i_emit,
    input  wire logic             i_out_ready,
    output logic                  o_room,
    output logic                  o_valid,
    output logic [CharW-1:0]      o_byte,
    output logic                  o_last
);

    logic [1:0]       r_cnt, n_cnt;
    logic [CharW-1:0] r_byte0, n_byte0;
    logic [CharW-1:0] r_byte1, n_byte1;
    logic             r_last0, n_last0;
    logic             r_last1, n_last1;
    logic             pop;

    assign pop     = (r_cnt != 2'd0) && i_out_ready;
    // a new request may enter once the buffer drains this cycle
    assign o_room  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign o_valid = (r_cnt != 2'd0);
    assign o_byte  = r_byte0;
    assign o_last  = r_last0;

    always_comb begin
        n_cnt   = r_cnt;
        n_byte0 = r_byte0;
        n_byte1 = r_byte1;
        n_last0 = r_last0;
        n_last1 = r_last1;
        if (i_push) begin
            n_cnt   = i_emit.n;
            n_byte0 = i_emit.hi;
            n_last0 = (i_emit.n == 2'd1);
            n_byte1 = i_emit.lo;
            n_last1 = 1'b1;
        end else if (pop) begin
            n_cnt   = r_cnt - 2'd1;
            n_byte0 = r_byte1;
            n_last0 = r_last1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_byte0 <= n_byte0;
        r_byte1 <= n_byte1;
        r_last0 <= n_last0;
        r_last1 <= n_last1;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overfilled");

    a_pair_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_cnt == 2'd2 && r_last1))
        else $error("non-final byte without its partner queued");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_emit.n == 2'd2) |=> (r_cnt == 2'd2 && !o_last))
        else $error("byte pair not loaded");
`endif

endmodule : cwa_out_buf

`default_nettype wire

// ----- tb/csv_word_to_ascii_pairs_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_word_to_ascii_pairs_tb
// streams text lines into the word-to-byte converter and checks every byte
// against a cycle-free parser of the same line format, with random source
// gaps and sink stalls
// ----------------------------------------------------------------------------

module csv_word_to_ascii_pairs_tb
    import cwa_pkg::*;
();

    localparam int unsigned QuietLimit = 2000;
    localparam int unsigned DrainLimit = 2000;
    localparam int unsigned CharTarget = 380;
    localparam logic [CharW-1:0] CHAR_TOP = 8'hFF;

    typedef struct packed {
        logic [CharW-1:0] data;
        logic             last;
    } t_out_byte;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic [CharW-1:0] s_axis_tdata = '0;   // [7:0] in_char
    logic             m_axis_tready = 1'b0;
    logic             s_axis_tready;
    logic             m_axis_tvalid;
    logic [CharW-1:0] m_axis_tdata;        // [7:0] out_byte
    logic             m_axis_tlast;        // last_of_run

    // parser state mirrored from the line format
    logic              past_first_col = 1'b0;
    logic              line_halted = 1'b0;
    logic              field_seen = 1'b0;
    logic [1:0]        scan_ph = PH_LEAD;
    logic              neg_word = 1'b0;
    logic [AccumW-1:0] word_acc = '0;

    t_out_byte        pending_bytes[$];
    logic [CharW-1:0] line_chars[$];
    int unsigned      err_count = 0;
    int unsigned      chars_sent = 0;
    int unsigned      quiet_cycles = 0;
    bit               src_idle_on = 1'b1;
    bit               sink_stall_on = 1'b1;

    csv_word_to_ascii_pairs dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic flag_error(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic is_blank(input logic [CharW-1:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT ||
               c == CHAR_FF || c == CHAR_CR;
    endfunction

    task automatic clear_field();
        field_seen = 1'b0;
        scan_ph    = PH_LEAD;
        neg_word   = 1'b0;
        word_acc   = '0;
    endtask

    // advance the parser by one accepted request, queue the bytes it gives
    task automatic parse_char(input logic [CharW-1:0] c);
        logic        digit;
        logic [19:0] wide;
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (c == CHAR_NEWLINE) begin
            past_first_col = 1'b0;
            line_halted    = 1'b0;
            clear_field();
        end else if (line_halted) begin
        end else if (c == CHAR_NUL) begin
            line_halted = 1'b1;
            clear_field();
        end else if (c != CHAR_COMMA) begin
            field_seen = 1'b1;
            if (scan_ph == PH_LEAD && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                neg_word = (c == CHAR_MINUS);
                scan_ph  = PH_NUM;
            end else begin
                if (scan_ph == PH_LEAD && !is_blank(c))
                    scan_ph = digit ? PH_NUM : PH_END;
                if (scan_ph == PH_NUM) begin
                    if (digit) begin
                        wide     = word_acc * 20'd10 + (c - CHAR_ZERO);
                        word_acc = (wide > ACCUM_MAX) ? ACCUM_MAX : wide[AccumW-1:0];
                    end else begin
                        scan_ph = PH_END;
                    end
                end
            end
        end else if (!past_first_col) begin
            past_first_col = 1'b1;
            clear_field();
        end else if (!field_seen) begin
            // an empty field ends the line
            line_halted = 1'b1;
            clear_field();
        end else begin
            if (!neg_word && word_acc != '0 && word_acc != WORD_DROP) begin
                pending_bytes.push_back(t_out_byte'{data: word_acc[15:8],
                                                    last: word_acc == WORD_HIGH_ONLY});
                if (word_acc != WORD_HIGH_ONLY)
                    pending_bytes.push_back(t_out_byte'{data: word_acc[7:0], last: 1'b1});
            end
            clear_field();
        end
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_char(input logic [CharW-1:0] c);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        parse_char(c);
        chars_sent++;
        gap = pick_gap(src_idle_on);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endtask

    task automatic push_blanks(input int unsigned n);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0: line_chars.push_back(CHAR_SPACE);
                1: line_chars.push_back(CHAR_TAB);
                2: line_chars.push_back(CHAR_VT);
                3: line_chars.push_back(CHAR_FF);
                default: line_chars.push_back(CHAR_CR);
            endcase
        end
    endtask

    task automatic push_random_field();
        int unsigned kind;
        string       junk;
        kind = $urandom_range(0, 99);
        junk = "xQ.;#/:";
        if (kind < 30) begin
            push_text($sformatf("%0d", $urandom_range(1, 255)));
        end else if (kind < 52) begin
            push_text($sformatf("%0d", $urandom_range(256, 65535)));
        end else if (kind < 57) begin
            push_text($sformatf("%0d", WORD_HIGH_ONLY));
        end else if (kind < 62) begin
            push_text($sformatf("%0d", WORD_DROP));
        end else if (kind < 65) begin
            push_text("0");
        end else if (kind < 70) begin
            // beyond 16 bits, clamps
            push_text($sformatf("%0d", $urandom_range(65536, 9999999)));
        end else if (kind < 76) begin
            push_text($sformatf("-%0d", $urandom_range(0, 70000)));
        end else if (kind < 83) begin
            push_blanks($urandom_range(1, 3));
            push_text($sformatf("+%0d", $urandom_range(0, 70000)));
        end else if (kind < 88) begin
            push_text($sformatf("%0d", $urandom_range(1, 65535)));
            line_chars.push_back(junk[$urandom_range(0, junk.len() - 1)]);
            push_text($sformatf("%0d", $urandom_range(0, 99)));
        end else if (kind < 91) begin
            push_text(($urandom_range(0, 1) != 0) ? "-" : "+");
        end else if (kind < 94) begin
            push_blanks($urandom_range(1, 4));
        end else begin
            push_text($sformatf("00%0d", $urandom_range(0, 65535)));
        end
    endtask

    task automatic send_line();
        foreach (line_chars[i])
            send_char(line_chars[i]);
    endtask

    task automatic test_word_values();
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        // first column skipped, two-byte word, high-only word, dropped word,
        // clamped word, trailing text without a comma
        send_text("a,16706,3338,2560,99999,7\n");
    endtask

    task automatic test_field_edges();
        send_char(CHAR_TOP);
        send_text(",-3,+,");
        send_char(CHAR_TAB);
        send_char(CHAR_VT);
        send_char(CHAR_FF);
        send_char(CHAR_CR);
        // empty field stops the line, so 9 never counts
        send_text(" ,+7x,007,,9,\n");
    endtask

    task automatic test_line_halt();
        send_text(",5");
        send_char(CHAR_NUL);
        send_text(",6,\n");
    endtask

    task automatic test_random_lines();
        int unsigned goal, r;
        goal = chars_sent + CharTarget;
        while (chars_sent < goal) begin
            src_idle_on   = ($urandom_range(0, 3) != 0);
            sink_stall_on = ($urandom_range(0, 3) != 0);
            line_chars.delete();
            if ($urandom_range(0, 9) == 0) begin
                // raw noise, any byte value
                repeat ($urandom_range(1, 20))
                    line_chars.push_back(CharW'($urandom_range(0, 255)));
            end else begin
                push_text($sformatf("t%0d", $urandom_range(0, 99)));
                line_chars.push_back(CHAR_COMMA);
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 99);
                    if (r >= 5) begin
                        if (r < 9)
                            line_chars.push_back(CHAR_NUL);
                        push_random_field();
                    end
                    line_chars.push_back(CHAR_COMMA);
                end
                if ($urandom_range(0, 3) == 0)
                    push_random_field();
            end
            line_chars.push_back(CHAR_NEWLINE);
            send_line();
        end
    endtask

    // sink stalls: mostly short, a few long
    initial begin : sink_pacing
        int unsigned hold, r;
        hold = 0;
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (hold != 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (sink_stall_on && r < 25) begin
                m_axis_tready <= 1'b0;
            end else if (sink_stall_on && r < 28) begin
                hold = $urandom_range(8, 30);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : byte_check
        t_out_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                flag_error($sformatf("unexpected byte %02h last %0b",
                                     m_axis_tdata, m_axis_tlast));
            end else begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want.data)
                    flag_error($sformatf("byte got %02h want %02h", m_axis_tdata, want.data));
                if (m_axis_tlast !== want.last)
                    flag_error($sformatf("last got %0b want %0b on byte %02h",
                                         m_axis_tlast, want.last, want.data));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QuietLimit) begin
            $display("[csv_word_to_ascii_pairs] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run
        int unsigned waited;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_word_values();
        test_field_edges();
        test_line_halt();
        test_random_lines();
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_bytes.size() != 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_bytes.size() != 0)
            flag_error($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
        if (err_count == 0)
            $display("[csv_word_to_ascii_pairs] OK");
        else
            $display("[csv_word_to_ascii_pairs] ERROR");
        $finish;
    end

endmodule
